// ----- hw/rtl/hdt_pkg.sv -----
// Package for the hex/decimal text to u32 parser.
// Phase codes, character constants and the digit decoder.
// No dependencies.
package hdt_pkg;

  localparam int unsigned ChW    = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned PhaseW = 3;

  localparam logic [PhaseW-1:0] PhLead   = 3'd0;
  localparam logic [PhaseW-1:0] PhZero   = 3'd1;
  localparam logic [PhaseW-1:0] PhPrefix = 3'd2;
  localparam logic [PhaseW-1:0] PhDigits = 3'd3;
  localparam logic [PhaseW-1:0] PhDone   = 3'd4;
  localparam logic [PhaseW-1:0] PhError  = 3'd5;

  localparam logic [ChW-1:0] ChNul   = 8'h00;
  localparam logic [ChW-1:0] ChTab   = 8'h09;
  localparam logic [ChW-1:0] ChSpace = 8'h20;
  localparam logic [ChW-1:0] ChHash  = 8'h23;
  localparam logic [ChW-1:0] Ch0     = 8'h30;
  localparam logic [ChW-1:0] Ch9     = 8'h39;
  localparam logic [ChW-1:0] ChUpA   = 8'h41;
  localparam logic [ChW-1:0] ChUpF   = 8'h46;
  localparam logic [ChW-1:0] ChUpX   = 8'h58;
  localparam logic [ChW-1:0] ChLoA   = 8'h61;
  localparam logic [ChW-1:0] ChLoF   = 8'h66;
  localparam logic [ChW-1:0] ChLoX   = 8'h78;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic logic is_blank(input logic [ChW-1:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic digit_t decode_digit(input logic [ChW-1:0] c, input logic hex);
    digit_t d;
    logic [ChW-1:0] diff;
    d.ok  = 1'b0;
    d.val = 4'd0;
    if (c >= Ch0 && c <= Ch9) begin
      diff  = c - Ch0;
      d.ok  = 1'b1;
      d.val = diff[3:0];
    end else if (hex && c >= ChLoA && c <= ChLoF) begin
      diff  = c - ChLoA;
      d.ok  = 1'b1;
      d.val = 4'd10 + diff[3:0];
    end else if (hex && c >= ChUpA && c <= ChUpF) begin
      diff  = c - ChUpA;
      d.ok  = 1'b1;
      d.val = 4'd10 + diff[3:0];
    end
    return d;
  endfunction

endpackage

// ----- hw/rtl/hex_decimal_text_to_u32.sv -----
// Streaming text to 32-bit number parser, top level.
// Depends on hdt_pkg.
//
// Usage:
//   s_axis carries one character per transaction in tdata[7:0]. A zero byte
//   terminates the string; it is the only character that produces a result.
//   m_axis carries the result: tdata[31:0] = value, tuser[0] = status
//   (0 ok, 1 malformed or empty; value is zero when status is 1).
//   Leading spaces/tabs are skipped, '#' or 0x/0X selects hex, otherwise
//   decimal. Digits accumulate modulo 2^32; a blank after the number ends
//   it and later characters up to the terminator are ignored.
// Timing:
//   The per-character update (one x10 or x16 plus digit add) completes in
//   the cycle the character is accepted; the result appears on m_axis in
//   the cycle after the terminator is accepted. Throughput is one character
//   per cycle while m_axis is not stalled, including back-to-back strings.
// Reset and stall:
//   rst_ni clears the parser to the leading-blank phase and drops m_axis
//   tvalid. While a result waits on m_axis with m_axis_tready low, no
//   character is taken: s_axis_tready = !m_axis_tvalid || m_axis_tready.
module hex_decimal_text_to_u32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value
  output logic [0:0]  m_axis_tuser    // [0] status
);

  logic [hdt_pkg::PhaseW-1:0] phase_q, phase_d;
  logic                       hex_q, hex_d;
  logic [hdt_pkg::ValueW-1:0] acc_q, acc_d;
  logic                       ovalid_q;
  logic [hdt_pkg::ValueW-1:0] value_q, value_d;
  logic                       status_q, status_d;

  logic                       in_acc;
  logic                       is_term;
  logic                       blank;
  hdt_pkg::digit_t            dig;
  logic [hdt_pkg::ValueW-1:0] acc_next;
  logic [hdt_pkg::ChW-1:0]    ch;

  assign ch            = s_axis_tdata;
  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_term       = (ch == hdt_pkg::ChNul);
  assign blank         = hdt_pkg::is_blank(ch);
  assign dig           = hdt_pkg::decode_digit(ch, hex_q);

  // x16 is a shift; x10 is x8 + x2
  always_comb begin
    if (hex_q) begin
      acc_next = {acc_q[hdt_pkg::ValueW-5:0], dig.val};
    end else begin
      acc_next = (acc_q << 3) + (acc_q << 1)
               + {{(hdt_pkg::ValueW-4){1'b0}}, dig.val};
    end
  end

  always_comb begin
    phase_d  = phase_q;
    hex_d    = hex_q;
    acc_d    = acc_q;
    status_d = 1'b0;
    value_d  = acc_q;
    if (is_term) begin
      status_d = !((phase_q == hdt_pkg::PhZero) || (phase_q == hdt_pkg::PhDigits) ||
                   (phase_q == hdt_pkg::PhDone));
      value_d  = status_d ? '0 : acc_q;
      phase_d  = hdt_pkg::PhLead;
      hex_d    = 1'b0;
      acc_d    = '0;
    end else begin
      case (phase_q)
        hdt_pkg::PhLead: begin
          if (blank) begin
            phase_d = hdt_pkg::PhLead;
          end else if (ch == hdt_pkg::ChHash) begin
            hex_d   = 1'b1;
            phase_d = hdt_pkg::PhPrefix;
          end else if (ch == hdt_pkg::Ch0) begin
            acc_d   = '0;
            phase_d = hdt_pkg::PhZero;
          end else if (dig.ok) begin
            acc_d   = acc_next;
            phase_d = hdt_pkg::PhDigits;
          end else begin
            phase_d = hdt_pkg::PhError;
          end
        end
        hdt_pkg::PhZero: begin
          if (ch == hdt_pkg::ChLoX || ch == hdt_pkg::ChUpX) begin
            hex_d   = 1'b1;
            phase_d = hdt_pkg::PhPrefix;
          end else if (blank) begin
            phase_d = hdt_pkg::PhDone;
          end else if (dig.ok) begin
            acc_d   = acc_next;
            phase_d = hdt_pkg::PhDigits;
          end else begin
            phase_d = hdt_pkg::PhError;
          end
        end
        hdt_pkg::PhPrefix, hdt_pkg::PhDigits: begin
          if (blank) begin
            phase_d = hdt_pkg::PhDone;
          end else if (dig.ok) begin
            acc_d   = acc_next;
            phase_d = hdt_pkg::PhDigits;
          end else begin
            phase_d = hdt_pkg::PhError;
          end
        end
        hdt_pkg::PhDone: begin
          phase_d = hdt_pkg::PhDone;
        end
        default: begin
          phase_d = hdt_pkg::PhError;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= hdt_pkg::PhLead;
      hex_q    <= 1'b0;
      acc_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
        hex_q   <= hex_d;
        acc_q   <= acc_d;
      end
      if (in_acc && is_term) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_term) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = value_q;
  assign m_axis_tuser  = status_q;

endmodule

// ----- hw/rtl/hdt_checker.sv -----
// Port-level checker for hex_decimal_text_to_u32, bound to the top level.
// Depends on hex_decimal_text_to_u32 port names only.
// Reports by $error.
module hdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // result is held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a bad status always carries a zero value
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
    else $error("nonzero value with bad status");

  // a terminator produces a result on the next cycle
  a_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata == 8'd0 |=> m_axis_tvalid)
    else $error("terminator without result");

  // ordinary characters never create a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata != 8'd0 && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("result without terminator");

endmodule

bind hex_decimal_text_to_u32 hdt_checker u_hdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
